@@ rtl/rss_pkg.sv @@
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants of the RTT smoother / clock sync unit
// Field widths, request and register codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int unsigned STAMP_BITS  = 48;
  localparam int unsigned RTT_BITS    = 16;
  localparam int unsigned SUM_BITS    = 24;
  localparam int unsigned CNT_BITS    = 8;
  localparam int unsigned EST_BITS    = 50;
  localparam int unsigned MARGIN_BITS = 16;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Derived widths
  localparam int unsigned EST_WIDE  = EST_BITS + 1;
  localparam int unsigned DIFF_BITS = RTT_BITS + 2;
  localparam int unsigned DVS_BITS  = CNT_BITS + 1;
  localparam int unsigned STEP_BITS = $clog2(SUM_BITS);

  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = MARGIN_BITS'(10);
  localparam logic [CNT_BITS-1:0]    WINDOW_RESET = CNT_BITS'(250);
  localparam logic [STEP_BITS-1:0]   DIV_LAST     = STEP_BITS'(SUM_BITS - 1);
  localparam logic [EST_BITS-1:0]    EST_MAX      = {1'b0, {(EST_BITS-1){1'b1}}};

  typedef enum logic [1:0] {
    REQ_RESET  = 2'd0,
    REQ_INIT   = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_QUERY  = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_OUTLIER_MARGIN = 2'd0,
    CFG_WINDOW_LIMIT   = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIVIDE = 4'b0010,
    ST_SMOOTH = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

endpackage

@@ rtl/rss_in_if.sv @@
// ----------------------------------------------------------------------------
// rss_in_if: request channel
// One transfer carries a request type, two time stamps and an RTT sample.
// ----------------------------------------------------------------------------
interface rss_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [rss_pkg::STAMP_BITS-1:0] server_time;
  logic [rss_pkg::STAMP_BITS-1:0] local_time;
  logic [rss_pkg::RTT_BITS-1:0]   rtt_sample;

  modport source (output valid, req_type, server_time, local_time, rtt_sample,
                  input ready);
  modport sink   (input valid, req_type, server_time, local_time, rtt_sample,
                  output ready);
endinterface

@@ rtl/rss_out_if.sv @@
// ----------------------------------------------------------------------------
// rss_out_if: result channel
// One transfer carries the init flag, smoothed RTT and server time estimate.
// ----------------------------------------------------------------------------
interface rss_out_if;
  logic                                valid;
  logic                                ready;
  logic                                initialised;
  logic [rss_pkg::RTT_BITS-1:0]         smoothed_rtt;
  logic signed [rss_pkg::EST_BITS-1:0]  server_time_estimate;

  modport source (output valid, initialised, smoothed_rtt, server_time_estimate,
                  input ready);
  modport sink   (input valid, initialised, smoothed_rtt, server_time_estimate,
                  output ready);
endinterface

@@ rtl/rss_cfg_if.sv @@
// ----------------------------------------------------------------------------
// rss_cfg_if: configuration write channel
// One transfer writes data to the register selected by index.
// ----------------------------------------------------------------------------
interface rss_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rss_pkg::CFG_IDX_BITS-1:0]  index;
  logic [rss_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/rtt_smoother_clock_sync_unit.sv @@
// ----------------------------------------------------------------------------
// rtt_smoother_clock_sync_unit: RTT smoother and server clock estimator
// Keeps the last server/local stamp pair and a smoothed RTT, and returns one
// result per request: init flag, smoothed RTT and the estimate
// server + (now - local) + rtt/2, saturated to the signed 50-bit range.
// Reset, init and query requests go straight from idle to the done state.
// An accepted update sample first runs its sum/count average through a
// serial restoring divider, one quotient bit per cycle over the 24-bit
// running sum, then takes a smoothing step. Input ready is high only while
// the sequencer is idle; a finished result waits in the output register
// while the next request is taken. Configuration writes are always ready.
// ----------------------------------------------------------------------------
module rtt_smoother_clock_sync_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  rss_in_if.sink     in_i,
  rss_out_if.source  out_o,
  rss_cfg_if.sink    cfg_i
);

  // Configuration
  logic [rss_pkg::MARGIN_BITS-1:0] margin_q;
  logic [rss_pkg::CNT_BITS-1:0]    window_q;

  // Block state
  logic                            init_q;
  logic [rss_pkg::STAMP_BITS-1:0]  server_q, server_d;
  logic [rss_pkg::STAMP_BITS-1:0]  local_q, local_d;
  logic [rss_pkg::RTT_BITS-1:0]    rtt_q, rtt_d;
  logic [rss_pkg::SUM_BITS-1:0]    sum_q, sum_d;
  logic [rss_pkg::CNT_BITS-1:0]    count_q, count_d;
  logic                            init_d;

  // Sequencer and divider
  rss_pkg::state_e                 state_q, state_d;
  logic [rss_pkg::STAMP_BITS-1:0]  now_q, now_d;
  logic                            norm_q, norm_d;
  logic [rss_pkg::SUM_BITS-1:0]    quo_q, quo_d;
  logic [rss_pkg::DVS_BITS-1:0]    rem_q, rem_d;
  logic [rss_pkg::DVS_BITS-1:0]    dvs_q, dvs_d;
  logic [rss_pkg::STEP_BITS-1:0]   step_q, step_d;

  // Output register
  logic                            out_valid_q, out_valid_d;
  logic                            out_init_q;
  logic [rss_pkg::RTT_BITS-1:0]    out_rtt_q;
  logic [rss_pkg::EST_BITS-1:0]    out_est_q;
  logic                            out_load;

  logic                            in_xfer;
  rss_pkg::req_e                   req;

  logic signed [rss_pkg::DIFF_BITS-1:0] rtt_diff;
  logic                            outlier;
  logic [rss_pkg::SUM_BITS-1:0]    sum_add;
  logic [rss_pkg::DVS_BITS-1:0]    next_cnt;
  logic                            renorm;

  logic [rss_pkg::DVS_BITS:0]      trial;
  logic [rss_pkg::DVS_BITS:0]      trial_sub;
  logic                            q_bit;
  logic [rss_pkg::SUM_BITS:0]      avg_sum;

  logic [rss_pkg::EST_WIDE-1:0]    est_wide;
  logic [rss_pkg::EST_BITS-1:0]    est_sat;

  assign in_i.ready  = (state_q == rss_pkg::ST_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign req         = rss_pkg::req_e'(in_i.req_type);
  assign cfg_i.ready = 1'b1;

  // Sample filter and running sum
  assign rtt_diff = $signed({2'b00, in_i.rtt_sample}) - $signed({2'b00, rtt_q});
  assign outlier  = rtt_diff >
                    $signed({{(rss_pkg::DIFF_BITS-rss_pkg::MARGIN_BITS){1'b0}}, margin_q});
  assign sum_add  = sum_q + {{(rss_pkg::SUM_BITS-rss_pkg::RTT_BITS){1'b0}}, in_i.rtt_sample};
  assign next_cnt = {1'b0, count_q} + rss_pkg::DVS_BITS'(1);
  assign renorm   = next_cnt > {1'b0, window_q};

  // Shared restoring divide step
  assign trial     = {rem_q, quo_q[rss_pkg::SUM_BITS-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign q_bit     = trial >= {1'b0, dvs_q};

  assign avg_sum = {1'b0, quo_q} +
                   {{(rss_pkg::SUM_BITS+1-rss_pkg::RTT_BITS){1'b0}}, rtt_q};

  // Estimate from the updated state; it can only overflow upward
  assign est_wide = {{(rss_pkg::EST_WIDE-rss_pkg::STAMP_BITS){1'b0}}, server_q}
                  + ({{(rss_pkg::EST_WIDE-rss_pkg::STAMP_BITS){1'b0}}, now_q}
                   - {{(rss_pkg::EST_WIDE-rss_pkg::STAMP_BITS){1'b0}}, local_q})
                  + {{(rss_pkg::EST_WIDE-rss_pkg::RTT_BITS+1){1'b0}},
                     rtt_q[rss_pkg::RTT_BITS-1:1]};
  assign est_sat  = (!est_wide[rss_pkg::EST_WIDE-1] && est_wide[rss_pkg::EST_BITS-1])
                  ? rss_pkg::EST_MAX : est_wide[rss_pkg::EST_BITS-1:0];

  assign out_load = (state_q == rss_pkg::ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    server_d    = server_q;
    local_d     = local_q;
    rtt_d       = rtt_q;
    sum_d       = sum_q;
    count_d     = count_q;
    now_d       = now_q;
    norm_d      = norm_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      rss_pkg::ST_IDLE: begin
        if (in_xfer) begin
          now_d   = in_i.local_time;
          state_d = rss_pkg::ST_DONE;
          unique case (req)
            rss_pkg::REQ_RESET: begin
              init_d   = 1'b0;
              server_d = '0;
              local_d  = '0;
              rtt_d    = '0;
              sum_d    = '0;
              count_d  = rss_pkg::CNT_BITS'(1);
            end
            rss_pkg::REQ_INIT: begin
              server_d = in_i.server_time;
              local_d  = in_i.local_time;
              rtt_d    = in_i.rtt_sample;
              init_d   = 1'b1;
            end
            rss_pkg::REQ_UPDATE: begin
              if (init_q && (server_q != '0)) begin
                server_d = in_i.server_time;
                local_d  = in_i.local_time;
                if (!outlier) begin
                  // Divide by the incremented count; on renormalization the count restarts at 1
                  sum_d   = sum_add;
                  norm_d  = renorm;
                  dvs_d   = renorm ? next_cnt : {1'b0, next_cnt[rss_pkg::CNT_BITS-1:0]};
                  count_d = renorm ? rss_pkg::CNT_BITS'(1)
                                   : next_cnt[rss_pkg::CNT_BITS-1:0];
                  quo_d   = sum_add;
                  rem_d   = '0;
                  step_d  = '0;
                  state_d = rss_pkg::ST_DIVIDE;
                end
              end
            end
            rss_pkg::REQ_QUERY: begin
            end
          endcase
        end
      end
      rss_pkg::ST_DIVIDE: begin
        rem_d  = q_bit ? trial_sub[rss_pkg::DVS_BITS-1:0] : trial[rss_pkg::DVS_BITS-1:0];
        quo_d  = {quo_q[rss_pkg::SUM_BITS-2:0], q_bit};
        step_d = step_q + rss_pkg::STEP_BITS'(1);
        if (step_q == rss_pkg::DIV_LAST) begin
          state_d = rss_pkg::ST_SMOOTH;
        end
      end
      rss_pkg::ST_SMOOTH: begin
        // After renormalization the count is 1, so the quotient is the target
        if (norm_q) begin
          sum_d = quo_q;
        end
        if (rtt_q == '0) begin
          rtt_d = quo_q[rss_pkg::RTT_BITS-1:0];
        end else begin
          rtt_d = avg_sum[rss_pkg::RTT_BITS:1];
        end
        state_d = rss_pkg::ST_DONE;
      end
      rss_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = rss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rss_pkg::ST_IDLE;
      init_q      <= 1'b0;
      server_q    <= '0;
      local_q     <= '0;
      rtt_q       <= '0;
      sum_q       <= '0;
      count_q     <= rss_pkg::CNT_BITS'(1);
      norm_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      margin_q    <= rss_pkg::MARGIN_RESET;
      window_q    <= rss_pkg::WINDOW_RESET;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      server_q    <= server_d;
      local_q     <= local_d;
      rtt_q       <= rtt_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      norm_q      <= norm_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == rss_pkg::CFG_OUTLIER_MARGIN) begin
          margin_q <= cfg_i.data[rss_pkg::MARGIN_BITS-1:0];
        end else if (cfg_i.index == rss_pkg::CFG_WINDOW_LIMIT) begin
          window_q <= cfg_i.data[rss_pkg::CNT_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    if (out_load) begin
      out_init_q <= init_q;
      out_rtt_q  <= rtt_q;
      out_est_q  <= est_sat;
    end
  end

  assign out_o.valid                = out_valid_q;
  assign out_o.initialised          = out_init_q;
  assign out_o.smoothed_rtt         = out_rtt_q;
  assign out_o.server_time_estimate = $signed(out_est_q);

`ifndef SYNTHESIS
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0)
    else $error("sample count is zero");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rss_pkg::ST_DIVIDE) |-> (dvs_q != '0))
    else $error("divider running with zero divisor");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rss_pkg::ST_DIVIDE) |-> (rem_q < dvs_q))
    else $error("partial remainder not below divisor");

  a_divide_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rss_pkg::ST_DIVIDE && step_q == rss_pkg::DIV_LAST)
      |=> (state_q == rss_pkg::ST_SMOOTH))
    else $error("divider did not hand over to smoothing");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == rss_pkg::ST_DONE))
    else $error("result loaded outside the done state");
`endif

endmodule

@@ tb/rtt_smoother_clock_sync_unit_test.sv @@
// ----------------------------------------------------------------------------
// rtt_smoother_clock_sync_unit_test: self-checking bench for the RTT smoother
// Drives reset, init, update and query requests under several register
// settings and idle patterns, predicts each result from a local copy of the
// sync state, and checks every returned transfer field by field, in order.
// ----------------------------------------------------------------------------
module rtt_smoother_clock_sync_unit_test;
  import rss_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 60;

  localparam longint EST_HIGH = 64'sd562949953421311;
  localparam longint EST_LOW  = -64'sd562949953421312;

  localparam logic [STAMP_BITS-1:0] STAMP_TOP = '1;
  localparam logic [RTT_BITS-1:0]   RTT_TOP   = '1;

  typedef struct packed {
    logic                initialised;
    logic [RTT_BITS-1:0] smoothed_rtt;
    logic [EST_BITS-1:0] estimate;
  } sync_result_t;

  logic clk_i;
  logic rst_ni;

  rss_in_if  in_if ();
  rss_out_if out_if ();
  rss_cfg_if cfg_if ();

  rtt_smoother_clock_sync_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // predicted sync state and register copies
  logic                  sync_init;
  logic [STAMP_BITS-1:0] sync_server;
  logic [STAMP_BITS-1:0] sync_local;
  logic [RTT_BITS-1:0]   sync_rtt;
  logic [SUM_BITS-1:0]   sync_sum;
  logic [CNT_BITS-1:0]   sync_count;
  logic [MARGIN_BITS-1:0] margin_reg;
  logic [CNT_BITS-1:0]   window_reg;

  sync_result_t pending_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int mismatches     = 0;

  // running stamps for well-formed traffic
  logic [STAMP_BITS-1:0] srv_now;
  logic [STAMP_BITS-1:0] loc_now;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_sync_state();
    sync_init   = 1'b0;
    sync_server = '0;
    sync_local  = '0;
    sync_rtt    = '0;
    sync_sum    = '0;
    sync_count  = CNT_BITS'(1);
  endfunction

  function automatic sync_result_t predict_result(input req_e req,
                                                  input logic [STAMP_BITS-1:0] srv,
                                                  input logic [STAMP_BITS-1:0] loc,
                                                  input logic [RTT_BITS-1:0] rtt);
    sync_result_t r;
    longint est, base_srv, base_loc, now_loc, half_rtt;
    int rise, lim;
    logic [8:0] next_cnt;
    logic [63:0] target, mid;
    case (req)
      REQ_RESET: clear_sync_state();
      REQ_INIT: begin
        sync_server = srv;
        sync_local  = loc;
        sync_rtt    = rtt;
        sync_init   = 1'b1;
      end
      REQ_UPDATE: begin
        if (sync_init && sync_server != '0) begin
          sync_server = srv;
          sync_local  = loc;
          rise = {16'b0, rtt} - {16'b0, sync_rtt};
          lim  = margin_reg;
          // drop samples that jump too far above the smoothed value
          if (rise <= lim) begin
            sync_sum = sync_sum + rtt;
            next_cnt = {1'b0, sync_count} + 9'd1;
            if (next_cnt > {1'b0, window_reg} || next_cnt > 9'd255) begin
              sync_sum = sync_sum / next_cnt;
              next_cnt = 9'd1;
            end
            sync_count = next_cnt[CNT_BITS-1:0];
            target = sync_sum / sync_count;
            if (sync_rtt == '0) begin
              sync_rtt = target[RTT_BITS-1:0];
            end else begin
              mid = {48'b0, sync_rtt} + target;
              sync_rtt = mid[RTT_BITS:1];
            end
          end
        end
      end
      default: ;
    endcase
    base_srv = sync_server;
    base_loc = sync_local;
    now_loc  = loc;
    half_rtt = sync_rtt >> 1;
    est = base_srv + (now_loc - base_loc) + half_rtt;
    if (est > EST_HIGH) est = EST_HIGH;
    if (est < EST_LOW) est = EST_LOW;
    r.initialised  = sync_init;
    r.smoothed_rtt = sync_rtt;
    r.estimate     = est[EST_BITS-1:0];
    return r;
  endfunction

  function automatic logic [STAMP_BITS-1:0] rand_stamp();
    return STAMP_BITS'({$urandom, $urandom});
  endfunction

  // mostly samples near the smoothed value, straddling the outlier margin
  function automatic logic [RTT_BITS-1:0] pick_rtt();
    int lo, hi;
    if ($urandom_range(9) == 0) return RTT_BITS'($urandom);
    lo = int'(sync_rtt) - int'(margin_reg) - 6;
    hi = int'(sync_rtt) + int'(margin_reg) + 6;
    if (lo < 0) lo = 0;
    if (hi > 65535) hi = 65535;
    return RTT_BITS'($urandom_range(hi, lo));
  endfunction

  task automatic send_request(input req_e req, input logic [STAMP_BITS-1:0] srv,
                              input logic [STAMP_BITS-1:0] loc,
                              input logic [RTT_BITS-1:0] rtt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.req_type    <= req;
    in_if.server_time <= srv;
    in_if.local_time  <= loc;
    in_if.rtt_sample  <= rtt;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(predict_result(req, srv, loc, rtt));
  endtask

  // hold the sender until every expected result is back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [MARGIN_BITS-1:0] margin,
                            input logic [CNT_BITS-1:0] window);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_OUTLIER_MARGIN;
    cfg_if.data  <= margin;
    do @(posedge clk_i); while (!cfg_if.ready);
    margin_reg = margin;
    cfg_if.index <= CFG_WINDOW_LIMIT;
    cfg_if.data  <= {8'h00, window};
    do @(posedge clk_i); while (!cfg_if.ready);
    window_reg = window;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(REQ_QUERY, '0, STAMP_TOP, '0);
    send_request(REQ_UPDATE, 48'd900, 48'd900, 16'd100);
    // init with a zero server stamp keeps updates blocked
    send_request(REQ_INIT, '0, 48'd1000, 16'd50);
    send_request(REQ_UPDATE, 48'd1200, 48'd1100, 16'd52);
    send_request(REQ_INIT, 48'd5000, 48'd2000, 16'd0);
    send_request(REQ_UPDATE, 48'd5100, 48'd2100, 16'd7);
    send_request(REQ_UPDATE, 48'd5200, 48'd2200, 16'd14);
    send_request(REQ_UPDATE, 48'd5300, 48'd2300, 16'd13);
    send_request(REQ_UPDATE, 48'd5400, 48'd2400, 16'd0);
    send_request(REQ_QUERY, '0, 48'd1500, '0);
    send_request(REQ_RESET, rand_stamp(), rand_stamp(), RTT_TOP);
    send_request(REQ_QUERY, STAMP_TOP, 48'd77, RTT_TOP);
    send_request(REQ_INIT, STAMP_TOP, '0, RTT_TOP);
    // elapsed time large enough to saturate the estimate
    send_request(REQ_QUERY, '0, STAMP_TOP, '0);
    send_request(REQ_UPDATE, STAMP_TOP, STAMP_TOP, RTT_TOP);
    send_request(REQ_INIT, 48'd1, STAMP_TOP, '0);
    send_request(REQ_QUERY, '0, '0, '0);
    send_request(REQ_UPDATE, 48'd2, STAMP_TOP, RTT_TOP);
    send_request(REQ_INIT, rand_stamp() | 48'd1, rand_stamp(), RTT_BITS'($urandom));
    send_request(REQ_UPDATE, rand_stamp(), rand_stamp(), RTT_BITS'($urandom));
    send_request(REQ_QUERY, rand_stamp(), rand_stamp(), RTT_BITS'($urandom));
  endtask

  task automatic test_window_renormalization();
    set_config(16'd0, 8'd1);
    send_request(REQ_INIT, 48'd10, 48'd10, 16'd100);
    send_request(REQ_UPDATE, 48'd20, 48'd20, 16'd100);
    send_request(REQ_UPDATE, 48'd30, 48'd30, 16'd60);
    send_request(REQ_UPDATE, 48'd40, 48'd40, sync_rtt + 16'd1);
    send_request(REQ_UPDATE, 48'd50, 48'd50, sync_rtt);
    set_config(16'hFFFF, 8'd2);
    send_request(REQ_UPDATE, 48'd60, 48'd60, RTT_TOP);
    send_request(REQ_UPDATE, 48'd70, 48'd70, 16'd3);
    send_request(REQ_UPDATE, 48'd80, 48'd80, 16'd4000);
    send_request(REQ_UPDATE, 48'd90, 48'd90, 16'd0);
  endtask

  task automatic test_random_traffic(input logic [MARGIN_BITS-1:0] margin,
                                     input logic [CNT_BITS-1:0] window,
                                     input int send_pct, input int recv_pct,
                                     input int count, input int reset_pct);
    req_e req;
    logic [STAMP_BITS-1:0] srv, loc;
    logic [RTT_BITS-1:0] rtt;
    int roll;
    set_config(margin, window);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    srv_now = rand_stamp();
    loc_now = rand_stamp();
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      srv_now = srv_now + $urandom_range(5000, 1);
      loc_now = loc_now + $urandom_range(5000, 1);
      srv = srv_now;
      loc = loc_now;
      rtt = pick_rtt();
      if (roll < 5) begin
        req = req_e'($urandom_range(3));
        if (reset_pct == 0 && req == REQ_RESET) req = REQ_QUERY;
        srv = rand_stamp();
        loc = rand_stamp();
        rtt = RTT_BITS'($urandom);
      end else if (roll < 5 + reset_pct) begin
        req = REQ_RESET;
      end else if (roll < 8 + reset_pct ||
                   ((!sync_init || sync_server == '0) && $urandom_range(4) != 0)) begin
        req = REQ_INIT;
        rtt = ($urandom_range(7) == 0) ? '0 : RTT_BITS'($urandom_range(3000));
        if ($urandom_range(19) == 0) srv = '0;
      end else if (roll < 92) begin
        req = REQ_UPDATE;
      end else begin
        req = REQ_QUERY;
        if ($urandom_range(1) == 0) loc = loc_now - $urandom_range(20000);
      end
      send_request(req, srv, loc, rtt);
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests <= hold_requests + 1;
    send_request(REQ_INIT, rand_stamp() | 48'd1, rand_stamp(), 16'd400);
    for (int i = 0; i < 12; i++) begin
      srv_now = srv_now + $urandom_range(5000, 1);
      loc_now = loc_now + $urandom_range(5000, 1);
      send_request((i % 3 == 2) ? REQ_QUERY : REQ_UPDATE, srv_now, loc_now, pick_rtt());
    end
  endtask

  task automatic test_drain_pause();
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    for (int i = 0; i < 16; i++) begin
      if (i == 8) drain_results();
      srv_now = srv_now + $urandom_range(5000, 1);
      loc_now = loc_now + $urandom_range(5000, 1);
      send_request(req_e'($urandom_range(3, 1)), srv_now, loc_now, pick_rtt());
    end
  endtask

  initial begin : result_monitor
    sync_result_t want, got;
    int hold_left, hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.initialised  = out_if.initialised;
        got.smoothed_rtt = out_if.smoothed_rtt;
        got.estimate     = out_if.server_time_estimate;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, got init=%0b rtt=%0d est=%0d",
                   $time, got.initialised, got.smoothed_rtt, $signed(got.estimate));
        end else begin
          want = pending_results.pop_front();
          if (got.initialised !== want.initialised ||
              got.smoothed_rtt !== want.smoothed_rtt ||
              got.estimate !== want.estimate) begin
            mismatches++;
            $display("%0t: mismatch: expected init=%0b rtt=%0d est=%0d,",
                     $time, want.initialised, want.smoothed_rtt, $signed(want.estimate),
                     " got init=%0b rtt=%0d est=%0d",
                     got.initialised, got.smoothed_rtt, $signed(got.estimate));
          end
        end
      end
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.req_type    = REQ_QUERY;
    in_if.server_time = '0;
    in_if.local_time  = '0;
    in_if.rtt_sample  = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_OUTLIER_MARGIN;
    cfg_if.data       = '0;
    margin_reg = MARGIN_RESET;
    window_reg = WINDOW_RESET;
    clear_sync_state();
    srv_now = rand_stamp();
    loc_now = rand_stamp();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_window_renormalization();
    test_random_traffic(16'd40, 8'd8, 0, 0, 150, 3);
    test_random_traffic(16'd0, 8'd1, 86, 0, 150, 3);
    test_random_traffic(16'hFFFF, 8'd254, 0, 86, 340, 0);
    test_random_traffic(16'd10, 8'd250, 23, 23, 100, 3);
    test_output_backpressure();
    test_drain_pause();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
